[hdl/swrg_pkg.sv]
// Shared types and constants of the sender whitelist replay gate.
package swrg_pkg;

  localparam int KEY_WORDS = 4;
  localparam int WORD_W    = 64;
  localparam int IN_W      = 520;  // 517 payload bits padded to whole bytes
  localparam int OUT_W     = 8;

  // gate_status codes
  localparam logic [2:0] GS_OK        = 3'd0;
  localparam logic [2:0] GS_INTERLOCK = 3'd1;
  localparam logic [2:0] GS_NO_SLOT   = 3'd2;
  localparam logic [2:0] GS_BAD_SEQ   = 3'd3;
  localparam logic [2:0] GS_EXPIRED   = 3'd4;
  localparam logic [2:0] GS_BAD_SIG   = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_RESOLVE,
    S_ENROLL,
    S_JUDGE,
    S_FINISH
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;          // capture input transfer
    logic scan_start;    // clear scan counters and flags
    logic scan_rd;       // read one key word, advance
    logic enroll_begin;  // claim free slot
    logic enroll_wr;     // write one key word into claimed slot
    logic judge;         // run sequence/time/signature checks
    logic fail_intlk;    // result: interlock
    logic fail_noslot;   // result: table full
    logic out_load;      // move result to output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic interlock;
    logic scan_last;
    logic found;
    logic free_found;
    logic enroll_last;
    logic out_free;
  } sts_t;

endpackage

[hdl/swrg_ram.sv]
// Generic single-port RAM with registered read.
module swrg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/swrg_ctrl.sv]
// Sequencing state machine of the gate.
module swrg_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  swrg_pkg::sts_t sts_i,
  output swrg_pkg::cmd_t cmd_o
);
  import swrg_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.interlock) begin
          cmd_o.fail_intlk = 1'b1;
          state_d          = S_FINISH;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_RESOLVE;  // last compare lands
      end
      S_RESOLVE: begin
        if (sts_i.found) begin
          state_d = S_JUDGE;  // sequence RAM reads the matched slot this cycle
        end else if (sts_i.free_found) begin
          cmd_o.enroll_begin = 1'b1;
          state_d            = S_ENROLL;
        end else begin
          cmd_o.fail_noslot = 1'b1;
          state_d           = S_FINISH;
        end
      end
      S_ENROLL: begin
        cmd_o.enroll_wr = 1'b1;
        if (sts_i.enroll_last) begin
          state_d = S_JUDGE;
        end
      end
      S_JUDGE: begin
        cmd_o.judge = 1'b1;
        state_d     = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  a_judge_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_JUDGE) |-> (sts_i.found || sts_i.free_found))
    else $error("judge without a matched or enrolled slot");

  a_enroll_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ENROLL) |-> !sts_i.found)
    else $error("enrolling a key that is already in the table");

  a_finish_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && !sts_i.out_free) |=> (state_q == S_FINISH))
    else $error("left finish while the output register was still full");

endmodule

[hdl/swrg_dp.sv]
// Datapath: input capture, slot table, key scan, checks and output register.
module swrg_dp #(
  parameter int SENDER_SLOTS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [swrg_pkg::IN_W-1:0]  in_data_i,
  input  swrg_pkg::cmd_t             cmd_i,
  output swrg_pkg::sts_t             sts_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [swrg_pkg::OUT_W-1:0] out_data_o
);
  import swrg_pkg::*;

  localparam int SW        = (SENDER_SLOTS > 1) ? $clog2(SENDER_SLOTS) : 1;
  localparam int KEY_DEPTH = KEY_WORDS * SENDER_SLOTS;
  localparam int KAW       = $clog2(KEY_DEPTH);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SENDER_SLOTS - 1);
  localparam logic [1:0]    LAST_WORD = 2'(KEY_WORDS - 1);

  // captured command
  logic [KEY_WORDS-1:0][WORD_W-1:0] key_q;
  logic [WORD_W-1:0] seq_q, issued_q, expiry_q, now_q;
  logic              sig_q;
  logic [3:0]        flags_q;

  // scan and table control
  logic [SENDER_SLOTS-1:0] valid_q;
  logic [SW-1:0] scan_slot_q, ev_slot_q, match_slot_q, free_slot_q, cur_slot;
  logic [1:0]    wcnt_q, ev_word_q;
  logic          ev_v_q, eq_run_q, found_q, free_found_q, enrolled_q;

  // result and output
  logic [2:0] res_status_q, out_status_q, judge_status;
  logic [3:0] res_slot_q, out_slot_q;
  logic       res_enr_q, out_enr_q, out_valid_q;

  // memories
  logic              key_we, seq_we;
  logic [KAW-1:0]    key_addr;
  logic [WORD_W-1:0] key_rdata, seq_rdata, seq_wdata, stored_seq;
  logic              word_eq, eq_now;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q[0] <= in_data_i[63:0];
      key_q[1] <= in_data_i[127:64];
      key_q[2] <= in_data_i[191:128];
      key_q[3] <= in_data_i[255:192];
      seq_q    <= in_data_i[319:256];
      issued_q <= in_data_i[383:320];
      expiry_q <= in_data_i[447:384];
      now_q    <= in_data_i[511:448];
      sig_q    <= in_data_i[512];
      flags_q  <= in_data_i[516:513];
    end
  end

  assign cur_slot = enrolled_q ? free_slot_q : match_slot_q;
  assign word_eq  = (key_rdata == key_q[ev_word_q]);
  assign eq_now   = (ev_word_q == 2'd0) ? word_eq : (eq_run_q & word_eq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      scan_slot_q  <= '0;
      wcnt_q       <= '0;
      ev_v_q       <= 1'b0;
      ev_slot_q    <= '0;
      ev_word_q    <= '0;
      eq_run_q     <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      match_slot_q <= '0;
      free_slot_q  <= '0;
      enrolled_q   <= 1'b0;
    end else begin
      ev_v_q    <= cmd_i.scan_rd;
      ev_slot_q <= scan_slot_q;
      ev_word_q <= wcnt_q;
      if (cmd_i.scan_start) begin
        scan_slot_q  <= '0;
        wcnt_q       <= '0;
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
        enrolled_q   <= 1'b0;
      end
      if (cmd_i.scan_rd) begin
        wcnt_q <= wcnt_q + 2'd1;
        if (wcnt_q == LAST_WORD) begin
          scan_slot_q <= scan_slot_q + 1'b1;
        end
      end
      // compare one key word per cycle, in the cycle after its read
      if (ev_v_q) begin
        eq_run_q <= eq_now;
        if (ev_word_q == LAST_WORD) begin
          if (valid_q[ev_slot_q] && eq_now && !found_q) begin
            found_q      <= 1'b1;
            match_slot_q <= ev_slot_q;
          end
          if (!valid_q[ev_slot_q] && !free_found_q) begin
            free_found_q <= 1'b1;
            free_slot_q  <= ev_slot_q;
          end
        end
      end
      if (cmd_i.enroll_begin) begin
        wcnt_q               <= '0;
        valid_q[free_slot_q] <= 1'b1;
        enrolled_q           <= 1'b1;
      end
      if (cmd_i.enroll_wr) begin
        wcnt_q <= wcnt_q + 2'd1;
      end
    end
  end

  // key store: scan reads, enrollment writes
  assign key_we   = cmd_i.enroll_wr;
  assign key_addr = cmd_i.enroll_wr ? KAW'({free_slot_q, wcnt_q}) : KAW'({scan_slot_q, wcnt_q});

  swrg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .addr_i  (key_addr),
    .wdata_i (key_q[wcnt_q]),
    .rdata_o (key_rdata)
  );

  // checks; a fresh enrollment counts as last sequence zero
  assign stored_seq = enrolled_q ? '0 : seq_rdata;

  always_comb begin
    if (seq_q <= stored_seq) begin
      judge_status = GS_BAD_SEQ;
    end else if ((now_q < issued_q) || (now_q > expiry_q)) begin
      judge_status = GS_EXPIRED;
    end else if (!sig_q) begin
      judge_status = GS_BAD_SIG;
    end else begin
      judge_status = GS_OK;
    end
  end

  assign seq_we    = cmd_i.judge && ((judge_status == GS_OK) || enrolled_q);
  assign seq_wdata = (judge_status == GS_OK) ? seq_q : '0;

  swrg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SENDER_SLOTS)
  ) u_seq_ram (
    .clk_i   (clk_i),
    .we_i    (seq_we),
    .addr_i  (cur_slot),
    .wdata_i (seq_wdata),
    .rdata_o (seq_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.judge) begin
      res_status_q <= judge_status;
      res_slot_q   <= 4'(cur_slot);
      res_enr_q    <= enrolled_q;
    end else if (cmd_i.fail_intlk) begin
      res_status_q <= GS_INTERLOCK;
      res_slot_q   <= '0;
      res_enr_q    <= 1'b0;
    end else if (cmd_i.fail_noslot) begin
      res_status_q <= GS_NO_SLOT;
      res_slot_q   <= '0;
      res_enr_q    <= 1'b0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_enr_q    <= res_enr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_enr_q, out_slot_q, out_status_q};

  assign sts_o.interlock   = |flags_q;
  assign sts_o.scan_last   = (scan_slot_q == LAST_SLOT) && (wcnt_q == LAST_WORD);
  assign sts_o.found       = found_q;
  assign sts_o.free_found  = free_found_q;
  assign sts_o.enroll_last = (wcnt_q == LAST_WORD);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  a_enroll_claimed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.enroll_wr |-> (free_found_q && valid_q[free_slot_q]))
    else $error("key written into a slot that was not claimed");

  a_judge_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.judge |-> (found_q || enrolled_q))
    else $error("checks run without a slot");

  a_enr_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_enr_q) |->
      (out_status_q != GS_INTERLOCK && out_status_q != GS_NO_SLOT))
    else $error("enrollment flagged on a refusal that never enrolls");

endmodule

[hdl/sender_whitelist_replay_gate.sv]
// Top level of the sender whitelist replay gate.
// A known key is judged after the full key scan; an unknown key is enrolled first,
// a full table is refused after the scan, and a tripped interlock skips the scan.
// One command at a time: the next input is taken only once the verdict is loaded,
// and the key scan reads one word a cycle; an untaken verdict stalls the next.
// Reset: asynchronous, active low; clears the slot valid bits, scan flags and verdict valid, not the RAMs.
module sender_whitelist_replay_gate #(
  parameter int SENDER_SLOTS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // command stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] key_word0, [127:64] key_word1, [191:128] key_word2, [255:192] key_word3,
  // [319:256] cmd_sequence, [383:320] issued_time, [447:384] expiry_time,
  // [511:448] current_time, [512] signature_ok, [516:513] interlock_flags,
  // [519:517] zero
  input  logic [519:0] s_axis_tdata,
  // verdict stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [2:0] gate_status, [6:3] slot_index, [7] newly_enrolled
  output logic [7:0]   m_axis_tdata
);
  import swrg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller walks check -> scan -> drain -> resolve -> (enroll) -> judge -> finish;
  // the input is registered on its transfer, so tdata need not hold afterwards.
  swrg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath holds the slot table: valid bits in flops, keys (4 words per
  // slot) and last sequences in RAM. The output register lets the next
  // command start while a verdict still waits for its transfer.
  swrg_dp #(
    .SENDER_SLOTS (SENDER_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
